// ===== rtl/kmc_pkg.sv =====
// kmc_pkg: shared types, field widths and codes of the 2-D k-means core.
// No dependencies; every other file but kmc_div refers to it by scoped names.
`timescale 1ns / 1ps

package kmc_pkg;

   localparam int COORD_W = 16;
   localparam int IDX_W   = 8;
   localparam int CID_W   = 3;
   localparam int MC_W    = 9;
   localparam int ST_W    = 2;
   localparam int NK_W    = 4;
   localparam int RND_W   = 8;
   localparam int CSR_W   = 8;
   localparam int CSR_IDX_W = 1;
   localparam int KMAX    = 8;
   localparam int K_W     = 3;
   localparam int DIST_W  = 2 * COORD_W + 1;

   localparam logic [1:0] REQ_LOAD      = 2'd0;
   localparam logic [1:0] REQ_RUN       = 2'd1;
   localparam logic [1:0] REQ_READ_PT   = 2'd2;
   localparam logic [1:0] REQ_READ_CENT = 2'd3;

   localparam logic [ST_W-1:0] ST_OK   = 2'd0;
   localparam logic [ST_W-1:0] ST_FULL = 2'd1;
   localparam logic [ST_W-1:0] ST_BAD  = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_NUM_CLUSTERS = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROUND_COUNT  = 1'b1;

   localparam logic [NK_W-1:0]  NK_RESET  = 4'd3;
   localparam logic [RND_W-1:0] RND_RESET = 8'd10;

   // response payload sources
   localparam logic [2:0] SRC_LOAD    = 3'd0;
   localparam logic [2:0] SRC_RUN_ERR = 3'd1;
   localparam logic [2:0] SRC_OK      = 3'd2;
   localparam logic [2:0] SRC_CENT    = 3'd3;
   localparam logic [2:0] SRC_PT      = 3'd4;

   typedef struct packed {
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [CID_W-1:0]   label;
   } point_type;

   typedef struct packed {
      logic           load;
      logic           pt_rd;
      logic           rsp_ld;
      logic [2:0]     rsp_src;
      logic           round_clr;
      logic           run_rd;
      logic           dist_en;
      logic           acc;
      logic           div_start;
      logic           div_wr;
      logic [K_W-1:0] k;
   } cmd_type;

   typedef struct packed {
      logic             run_err;
      logic             last_k;
      logic             last_point;
      logic [RND_W-1:0] rounds;
      logic             div_done;
   } stat_type;

endpackage

// ===== rtl/kmc_ifs.sv =====
// Valid/ready channel interfaces for the request and response items.
// Depends on kmc_pkg for field widths.
`timescale 1ns / 1ps

interface kmc_req_if;
   logic                        valid;
   logic                        ready;
   logic [1:0]                  req_type;
   logic [kmc_pkg::COORD_W-1:0] in_x;
   logic [kmc_pkg::COORD_W-1:0] in_y;
   logic                        make_seed;
   logic [kmc_pkg::IDX_W-1:0]   read_index;

   modport source (output valid, req_type, in_x, in_y, make_seed, read_index, input ready);
   modport sink   (input valid, req_type, in_x, in_y, make_seed, read_index, output ready);
endinterface

interface kmc_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [kmc_pkg::ST_W-1:0]    status;
   logic [kmc_pkg::CID_W-1:0]   cluster_id;
   logic [kmc_pkg::COORD_W-1:0] out_x;
   logic [kmc_pkg::COORD_W-1:0] out_y;
   logic [kmc_pkg::MC_W-1:0]    member_count;

   modport source (output valid, status, cluster_id, out_x, out_y, member_count,
                   input ready);
   modport sink   (input valid, status, cluster_id, out_x, out_y, member_count,
                   output ready);
endinterface

// ===== rtl/kmc_div.sv =====
// kmc_div: two-lane restoring divider, one quotient bit per cycle.
// Both lanes share the divisor. Standalone; no package use.
`timescale 1ns / 1ps

module kmc_div #(
   parameter int DVD_W = 25,
   parameter int DVS_W = 9
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DVD_W-1:0] dividend_x,
   input  logic [DVD_W-1:0] dividend_y,
   input  logic [DVS_W-1:0] divisor,
   output logic [DVD_W-1:0] quot_x,
   output logic [DVD_W-1:0] quot_y,
   output logic             done
);
   localparam int CNT_W = $clog2(DVD_W + 1);

   logic [DVD_W-1:0] qx_ff, qx_in, qy_ff, qy_in;
   logic [DVS_W-1:0] rx_ff, rx_in, ry_ff, ry_in, d_ff;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in, done_ff, done_in;
   logic [DVS_W:0]   tx, ty;
   logic             gex, gey;

   assign tx  = {rx_ff, qx_ff[DVD_W-1]};
   assign ty  = {ry_ff, qy_ff[DVD_W-1]};
   assign gex = tx >= {1'b0, d_ff};
   assign gey = ty >= {1'b0, d_ff};

   always_comb begin
      qx_in = qx_ff; qy_in = qy_ff; rx_in = rx_ff; ry_in = ry_ff;
      cnt_in = cnt_ff; busy_in = busy_ff; done_in = done_ff;
      if (start) begin
         qx_in = dividend_x; qy_in = dividend_y;
         rx_in = '0; ry_in = '0;
         cnt_in = '0; busy_in = 1'b1; done_in = 1'b0;
      end else if (busy_ff) begin
         rx_in = gex ? DVS_W'(tx - {1'b0, d_ff}) : DVS_W'(tx);
         ry_in = gey ? DVS_W'(ty - {1'b0, d_ff}) : DVS_W'(ty);
         qx_in = {qx_ff[DVD_W-2:0], gex};
         qy_in = {qy_ff[DVD_W-2:0], gey};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(DVD_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      qx_ff <= qx_in;
      qy_ff <= qy_in;
      rx_ff <= rx_in;
      ry_ff <= ry_in;
      if (start) d_ff <= divisor;
   end

   assign quot_x = qx_ff;
   assign quot_y = qy_ff;
   assign done   = done_ff;
endmodule

// ===== rtl/kmc_datapath.sv =====
// kmc_datapath: point store, centroids, sums, distance unit, registers, response payload.
// Depends on kmc_pkg and kmc_div.
`timescale 1ns / 1ps

module kmc_datapath #(
   parameter int MAX_POINTS = 256
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [kmc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [kmc_pkg::CSR_W-1:0]          csr_data,
   input  logic [kmc_pkg::COORD_W-1:0]        in_x,
   input  logic [kmc_pkg::COORD_W-1:0]        in_y,
   input  logic                               make_seed,
   input  logic [kmc_pkg::IDX_W-1:0]          read_index,
   input  kmc_pkg::cmd_type                   cmd,
   input  logic [$clog2(MAX_POINTS)-1:0]      pidx,
   output kmc_pkg::stat_type                  st,
   output logic [kmc_pkg::ST_W-1:0]           status,
   output logic [kmc_pkg::CID_W-1:0]          cluster_id,
   output logic [kmc_pkg::COORD_W-1:0]        out_x,
   output logic [kmc_pkg::COORD_W-1:0]        out_y,
   output logic [kmc_pkg::MC_W-1:0]           member_count
);
   localparam int PIDX_W = $clog2(MAX_POINTS);
   localparam int CNT_W  = $clog2(MAX_POINTS + 1);
   localparam int SUM_W  = kmc_pkg::COORD_W + CNT_W;
   localparam int CMP_W  = (CNT_W > kmc_pkg::IDX_W) ? CNT_W : kmc_pkg::IDX_W;
   localparam int CW     = kmc_pkg::COORD_W;

   logic [kmc_pkg::NK_W-1:0]  num_clusters_ff;
   logic [kmc_pkg::RND_W-1:0] round_count_ff;
   logic [kmc_pkg::NK_W-1:0]  nk;

   kmc_pkg::point_type mem [MAX_POINTS];
   kmc_pkg::point_type rdata_ff, wdata;
   logic               we, re;
   logic [PIDX_W-1:0]  waddr, raddr;

   logic [CNT_W-1:0]        pts_ff;
   logic [kmc_pkg::NK_W-1:0] seeds_ff;
   logic [CW-1:0]           cx_ff [kmc_pkg::KMAX];
   logic [CW-1:0]           cy_ff [kmc_pkg::KMAX];
   logic [SUM_W-1:0]        sx_ff [kmc_pkg::KMAX];
   logic [SUM_W-1:0]        sy_ff [kmc_pkg::KMAX];
   logic [CNT_W-1:0]        cnt_ff [kmc_pkg::KMAX];

   logic [2*CW-1:0]             prodx_ff, prody_ff;
   logic                        pvalid_ff;
   logic [kmc_pkg::K_W-1:0]     pk_ff, bidx_ff;
   logic [kmc_pkg::DIST_W-1:0]  best_ff, dsum;
   logic [CW-1:0]               dx, dy, ccx, ccy;
   logic                        pt_ok_ff;

   logic [CMP_W-1:0]        idx_ext;
   logic [kmc_pkg::K_W-1:0] cidx;
   logic                    full;
   logic [SUM_W-1:0]        qx, qy;
   logic                    div_done;

   assign nk = (num_clusters_ff == '0) ? kmc_pkg::NK_W'(1) :
               (num_clusters_ff > kmc_pkg::NK_W'(kmc_pkg::KMAX)) ?
               kmc_pkg::NK_W'(kmc_pkg::KMAX) : num_clusters_ff;
   assign idx_ext = CMP_W'(read_index);
   assign cidx    = read_index[kmc_pkg::K_W-1:0];
   assign full    = (pts_ff == CNT_W'(MAX_POINTS));

   assign st.run_err    = (pts_ff == '0) || (seeds_ff < nk);
   assign st.last_k     = (cmd.k == kmc_pkg::K_W'(nk - 1'b1));
   assign st.last_point = (CNT_W'(pidx) == pts_ff - 1'b1);
   assign st.rounds     = round_count_ff;
   assign st.div_done   = div_done;

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         num_clusters_ff <= kmc_pkg::NK_RESET;
         round_count_ff  <= kmc_pkg::RND_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            kmc_pkg::CSR_NUM_CLUSTERS: num_clusters_ff <= csr_data[kmc_pkg::NK_W-1:0];
            kmc_pkg::CSR_ROUND_COUNT:  round_count_ff  <= csr_data[kmc_pkg::RND_W-1:0];
            default: ;
         endcase
      end
   end

   // point store
   always_comb begin
      we    = 1'b0;
      waddr = pidx;
      wdata = rdata_ff;
      if (cmd.load && !full) begin
         we    = 1'b1;
         waddr = pts_ff[PIDX_W-1:0];
         wdata = '{x: in_x, y: in_y, label: '0};
      end else if (cmd.acc) begin
         we          = 1'b1;
         wdata.label = bidx_ff;
      end
      re    = cmd.pt_rd || cmd.run_rd;
      raddr = cmd.pt_rd ? idx_ext[PIDX_W-1:0] : pidx;
   end

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      if (re) rdata_ff <= mem[raddr];
   end

   // distance: products registered, then fold into running minimum
   assign ccx  = cx_ff[cmd.k];
   assign ccy  = cy_ff[cmd.k];
   assign dx   = (rdata_ff.x >= ccx) ? rdata_ff.x - ccx : ccx - rdata_ff.x;
   assign dy   = (rdata_ff.y >= ccy) ? rdata_ff.y - ccy : ccy - rdata_ff.y;
   assign dsum = {1'b0, prodx_ff} + {1'b0, prody_ff};

   always_ff @(posedge clock) begin
      if (reset) pvalid_ff <= 1'b0;
      else       pvalid_ff <= cmd.dist_en;
      if (cmd.dist_en) begin
         prodx_ff <= dx * dx;
         prody_ff <= dy * dy;
         pk_ff    <= cmd.k;
      end
      // strict less-than: lowest index wins a tie
      if (pvalid_ff && (pk_ff == '0 || dsum < best_ff)) begin
         best_ff <= dsum;
         bidx_ff <= pk_ff;
      end
   end

   kmc_div #(.DVD_W(SUM_W), .DVS_W(CNT_W)) u_div (
      .clock      (clock),
      .reset      (reset),
      .start      (cmd.div_start),
      .dividend_x (sx_ff[cmd.k]),
      .dividend_y (sy_ff[cmd.k]),
      .divisor    (cnt_ff[cmd.k]),
      .quot_x     (qx),
      .quot_y     (qy),
      .done       (div_done)
   );

   // counters, centroids, per-cluster sums
   always_ff @(posedge clock) begin
      if (reset) begin
         pts_ff   <= '0;
         seeds_ff <= '0;
         for (int i = 0; i < kmc_pkg::KMAX; i++) begin
            cx_ff[i]  <= '0;
            cy_ff[i]  <= '0;
            cnt_ff[i] <= '0;
         end
      end else begin
         if (cmd.load && !full) begin
            pts_ff <= pts_ff + 1'b1;
            if (make_seed && seeds_ff < kmc_pkg::NK_W'(kmc_pkg::KMAX)) begin
               cx_ff[seeds_ff[kmc_pkg::K_W-1:0]] <= in_x;
               cy_ff[seeds_ff[kmc_pkg::K_W-1:0]] <= in_y;
               seeds_ff <= seeds_ff + 1'b1;
            end
         end
         if (cmd.round_clr) begin
            for (int i = 0; i < kmc_pkg::KMAX; i++) begin
               cnt_ff[i] <= '0;
            end
         end else if (cmd.acc) begin
            cnt_ff[bidx_ff] <= cnt_ff[bidx_ff] + 1'b1;
         end
         if (cmd.div_wr && cnt_ff[cmd.k] != '0) begin
            cx_ff[cmd.k] <= qx[CW-1:0];
            cy_ff[cmd.k] <= qy[CW-1:0];
         end
      end
      if (cmd.round_clr) begin
         for (int i = 0; i < kmc_pkg::KMAX; i++) begin
            sx_ff[i] <= '0;
            sy_ff[i] <= '0;
         end
      end else if (cmd.acc) begin
         sx_ff[bidx_ff] <= sx_ff[bidx_ff] + SUM_W'(rdata_ff.x);
         sy_ff[bidx_ff] <= sy_ff[bidx_ff] + SUM_W'(rdata_ff.y);
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      if (cmd.pt_rd) pt_ok_ff <= idx_ext < CMP_W'(pts_ff);
      if (cmd.rsp_ld) begin
         status       <= kmc_pkg::ST_OK;
         cluster_id   <= '0;
         out_x        <= '0;
         out_y        <= '0;
         member_count <= '0;
         case (cmd.rsp_src)
            kmc_pkg::SRC_LOAD:    status <= full ? kmc_pkg::ST_FULL : kmc_pkg::ST_OK;
            kmc_pkg::SRC_RUN_ERR: status <= kmc_pkg::ST_BAD;
            kmc_pkg::SRC_CENT: begin
               if (idx_ext < CMP_W'(nk)) begin
                  cluster_id   <= cidx;
                  out_x        <= cx_ff[cidx];
                  out_y        <= cy_ff[cidx];
                  member_count <= kmc_pkg::MC_W'(cnt_ff[cidx]);
               end else begin
                  status <= kmc_pkg::ST_BAD;
               end
            end
            kmc_pkg::SRC_PT: begin
               if (pt_ok_ff) begin
                  cluster_id <= rdata_ff.label;
                  out_x      <= rdata_ff.x;
                  out_y      <= rdata_ff.y;
               end else begin
                  status <= kmc_pkg::ST_BAD;
               end
            end
            default: ;
         endcase
      end
   end
endmodule

// ===== rtl/kmc_ctrl.sv =====
// kmc_ctrl: sequencer for loads, reads and clustering rounds; owns the
// response valid flag. Depends on kmc_pkg.
`timescale 1ns / 1ps

module kmc_ctrl #(
   parameter int MAX_POINTS = 256
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [1:0]                    req_type,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  kmc_pkg::stat_type             st,
   output kmc_pkg::cmd_type              cmd,
   output logic [$clog2(MAX_POINTS)-1:0] pidx
);
   localparam int PIDX_W = $clog2(MAX_POINTS);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_PTRD = 3'd1;
   localparam logic [2:0] S_RD   = 3'd2;
   localparam logic [2:0] S_DIST = 3'd3;
   localparam logic [2:0] S_FOLD = 3'd4;
   localparam logic [2:0] S_ACC  = 3'd5;
   localparam logic [2:0] S_DIVS = 3'd6;
   localparam logic [2:0] S_DIVW = 3'd7;

   logic [2:0]                 state_ff, state_in;
   logic [PIDX_W-1:0]          pidx_ff, pidx_in;
   logic [kmc_pkg::K_W-1:0]    k_ff, k_in;
   logic [kmc_pkg::RND_W-1:0]  rnd_ff, rnd_in;
   logic                       rv_ff, rv_in;
   logic                       accept;

   assign req_ready = (state_ff == S_IDLE) && (!rv_ff || rsp_ready);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rv_ff;
   assign pidx      = pidx_ff;

   always_comb begin
      state_in = state_ff;
      pidx_in  = pidx_ff;
      k_in     = k_ff;
      rnd_in   = rnd_ff;
      cmd      = '0;
      cmd.k    = k_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               unique case (req_type)
                  kmc_pkg::REQ_LOAD: begin
                     cmd.load    = 1'b1;
                     cmd.rsp_ld  = 1'b1;
                     cmd.rsp_src = kmc_pkg::SRC_LOAD;
                  end
                  kmc_pkg::REQ_RUN: begin
                     if (st.run_err) begin
                        cmd.rsp_ld  = 1'b1;
                        cmd.rsp_src = kmc_pkg::SRC_RUN_ERR;
                     end else if (st.rounds == '0) begin
                        cmd.rsp_ld  = 1'b1;
                        cmd.rsp_src = kmc_pkg::SRC_OK;
                     end else begin
                        cmd.round_clr = 1'b1;
                        pidx_in  = '0;
                        rnd_in   = '0;
                        state_in = S_RD;
                     end
                  end
                  kmc_pkg::REQ_READ_PT: begin
                     cmd.pt_rd = 1'b1;
                     state_in  = S_PTRD;
                  end
                  kmc_pkg::REQ_READ_CENT: begin
                     cmd.rsp_ld  = 1'b1;
                     cmd.rsp_src = kmc_pkg::SRC_CENT;
                  end
                  default: ;
               endcase
            end
         end
         S_PTRD: begin
            cmd.rsp_ld  = 1'b1;
            cmd.rsp_src = kmc_pkg::SRC_PT;
            state_in    = S_IDLE;
         end
         S_RD: begin
            cmd.run_rd = 1'b1;
            k_in       = '0;
            state_in   = S_DIST;
         end
         S_DIST: begin
            cmd.dist_en = 1'b1;
            if (st.last_k) state_in = S_FOLD;
            else           k_in = k_ff + 1'b1;
         end
         S_FOLD: state_in = S_ACC;
         S_ACC: begin
            cmd.acc = 1'b1;
            if (st.last_point) begin
               k_in     = '0;
               state_in = S_DIVS;
            end else begin
               pidx_in  = pidx_ff + 1'b1;
               state_in = S_RD;
            end
         end
         S_DIVS: begin
            cmd.div_start = 1'b1;
            state_in      = S_DIVW;
         end
         S_DIVW: begin
            if (st.div_done) begin
               cmd.div_wr = 1'b1;
               if (!st.last_k) begin
                  k_in     = k_ff + 1'b1;
                  state_in = S_DIVS;
               end else if (rnd_ff == st.rounds - 1'b1) begin
                  cmd.rsp_ld  = 1'b1;
                  cmd.rsp_src = kmc_pkg::SRC_OK;
                  state_in    = S_IDLE;
               end else begin
                  cmd.round_clr = 1'b1;
                  rnd_in   = rnd_ff + 1'b1;
                  pidx_in  = '0;
                  state_in = S_RD;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
      rv_in = cmd.rsp_ld ? 1'b1 : (rsp_ready ? 1'b0 : rv_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         pidx_ff  <= '0;
         k_ff     <= '0;
         rnd_ff   <= '0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         pidx_ff  <= pidx_in;
         k_ff     <= k_in;
         rnd_ff   <= rnd_in;
         rv_ff    <= rv_in;
      end
   end
endmodule

// ===== rtl/kmeans_cluster_2d_core.sv =====
// Top level of the 2-D k-means core: controller plus datapath.
// Depends on kmc_pkg, kmc_ifs, kmc_ctrl, kmc_datapath, kmc_div.
`timescale 1ns / 1ps

// One item at a time. A load or a centroid read is answered from the idle state; a
// point read first passes the registered read of the point store. A run repeats
// round_count rounds over the P loaded points and the K clusters in use: each point
// is one store read, one distance step per centroid, a fold and an accumulate; each
// centroid update runs the bit-serial divider over an S-bit dividend, where
// S = 16 + clog2(MAX_POINTS + 1) (25 by default). A finished response waits in its
// output register, and the next request is taken as soon as that register is free or
// being drained.
module kmeans_cluster_2d_core #(
   parameter int MAX_POINTS = 256
) (
   input  logic                              clock,
   input  logic                              reset,
   kmc_req_if.sink                           req_if,
   kmc_rsp_if.source                         rsp_if,
   input  logic                              csr_we,
   input  logic [kmc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [kmc_pkg::CSR_W-1:0]         csr_data
);
   kmc_pkg::cmd_type              cmd;
   kmc_pkg::stat_type             st;
   logic [$clog2(MAX_POINTS)-1:0] pidx;

   kmc_ctrl #(.MAX_POINTS(MAX_POINTS)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .req_type  (req_if.req_type),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .st        (st),
      .cmd       (cmd),
      .pidx      (pidx)
   );

   kmc_datapath #(.MAX_POINTS(MAX_POINTS)) u_dp (
      .clock        (clock),
      .reset        (reset),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .in_x         (req_if.in_x),
      .in_y         (req_if.in_y),
      .make_seed    (req_if.make_seed),
      .read_index   (req_if.read_index),
      .cmd          (cmd),
      .pidx         (pidx),
      .st           (st),
      .status       (rsp_if.status),
      .cluster_id   (rsp_if.cluster_id),
      .out_x        (rsp_if.out_x),
      .out_y        (rsp_if.out_y),
      .member_count (rsp_if.member_count)
   );

   a_accept_slot_free: assert property (@(posedge clock) disable iff (reset)
      (req_if.valid && req_if.ready) |-> (!rsp_if.valid || rsp_if.ready))
      else $error("item accepted while response slot held");

   a_one_op: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.pt_rd, cmd.run_rd, cmd.dist_en, cmd.acc,
                cmd.div_start, cmd.div_wr}))
      else $error("datapath commands overlap");

   a_div_wr_done: assert property (@(posedge clock) disable iff (reset)
      cmd.div_wr |-> st.div_done)
      else $error("centroid written before divider finished");

   a_pt_rsp: assert property (@(posedge clock) disable iff (reset)
      cmd.pt_rd |=> (cmd.rsp_ld && cmd.rsp_src == kmc_pkg::SRC_PT))
      else $error("point read not answered next cycle");
endmodule
